// ===== rtl/core/diagonal_half_step_gait_sequencer_top_assert.svh =====
// assertion macros for the gait sequencer top
// each macro needs clk and rst_n in the module that uses it
`ifndef DIAGONAL_HALF_STEP_GAIT_SEQUENCER_TOP_ASSERT_SVH
`define DIAGONAL_HALF_STEP_GAIT_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// consequent must hold at the same edge as the antecedent
`define DHSG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent must hold at the edge after the antecedent
`define DHSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DHSG_ASSERT_SAME(label, ante, cons, msg)
`define DHSG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/dhsg_pkg.sv =====
`timescale 1ns / 1ps

package dhsg_pkg;

    // time arithmetic width, times wrap modulo 2^TIME_BITS
    localparam int TIME_BITS    = 32;
    localparam int NOW_BITS     = 32;
    // widest sum of three 16-bit durations
    localparam int SPAN_BITS    = 18;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_BITS = 3;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LEG_LIFT_MS      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEG_DROP_MS      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BODY_LEAD_IN_MS  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTUATE_MS       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BODY_SETTLE_MS   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIFT_FRACTION    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTUATE_FRACTION = 3'd6;

    // register reset values
    localparam logic [15:0]        RST_LEG_LIFT_MS      = 16'd200;
    localparam logic [15:0]        RST_LEG_DROP_MS      = 16'd200;
    localparam logic [15:0]        RST_BODY_LEAD_IN_MS  = 16'd100;
    localparam logic [15:0]        RST_ACTUATE_MS       = 16'd200;
    localparam logic [15:0]        RST_BODY_SETTLE_MS   = 16'd100;
    localparam logic signed [15:0] RST_LIFT_FRACTION    = 16'sd16384;
    localparam logic [14:0]        RST_ACTUATE_FRACTION = 15'd32767;

    // first leg of each diagonal pair
    localparam logic [2:0] LEG_A_FIRST = 3'd0;
    localparam logic [2:0] LEG_B_FIRST = 3'd2;

    typedef logic [TIME_BITS-1:0] tstamp_t;

    typedef struct packed {
        logic                  cmd;
        logic [NOW_BITS-1:0]   now_ms;
        logic [2:0]            body_servo;
        logic signed [15:0]    half_steps;
    } item_t;

    typedef struct packed {
        logic                  cmd_valid;
        logic [2:0]            servo_id;
        logic signed [15:0]    target_fraction;
        logic [15:0]           move_ms;
        logic                  done_res;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic [15:0]           leg_lift_ms;
        logic [15:0]           leg_drop_ms;
        logic [15:0]           body_lead_in_ms;
        logic [15:0]           actuate_ms;
        logic [15:0]           body_settle_ms;
        logic signed [15:0]    lift_fraction;
        logic [14:0]           actuate_fraction;
    } cfg_t;

    // half-step spans derived from the configuration
    typedef struct packed {
        logic [SPAN_BITS-1:0]  total;
        logic [SPAN_BITS-1:0]  to_drop;
    } span_t;

    // classified item: which commands the back end must issue
    typedef struct packed {
        logic                  act;
        logic signed [15:0]    act_frac;
        logic [2:0]            body_id;
        logic                  drop;
        logic                  drop_diag_a;
        logic                  lift;
        logic                  lift_diag_a;
        logic                  done;
    } plan_t;

    typedef struct packed {
        logic                  full;
        logic                  not_empty;
        logic [FIFO_AW:0]      count;
    } fifo_stat_t;

    function automatic tstamp_t to_tstamp(input logic [NOW_BITS-1:0] v);
        return TIME_BITS'(v);
    endfunction

    // true when now has reached t by wrapping signed difference
    function automatic logic reached(input tstamp_t now, input tstamp_t t);
        tstamp_t d;
        d = now - t;
        return ~d[TIME_BITS-1];
    endfunction

    function automatic logic [2:0] leg_first(input logic diag_a);
        return diag_a ? LEG_A_FIRST : LEG_B_FIRST;
    endfunction

endpackage

// ===== rtl/core/diagonal_half_step_gait_sequencer_top.sv =====
// channel   | handshake               | word
// ----------+-------------------------+----------------------------------
// item      | push / full             | item_t: cmd, now_ms, servo, steps
// result    | pop / empty             | result_t: servo move, done, last
// cfg       | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// the front end takes one item per cycle while full is low and queues a plan (4 deep)
// the back end issues one result word per cycle unless the result port stalls,
// 1 to 5 words per item, set by the number of servo commands that the item causes
// full is high for the first cycle after reset and in the cycle after each
// register write while the derived half-step spans reload
// a stalled result port fills the plan queue, then full rises
`timescale 1ns / 1ps
`include "diagonal_half_step_gait_sequencer_top_assert.svh"

module diagonal_half_step_gait_sequencer_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  dhsg_pkg::item_t                       item,
    output logic                                  empty,
    input  logic                                  pop,
    output dhsg_pkg::result_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dhsg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [15:0]                           cfg_data
);
    import dhsg_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    span_t      span_reg, span_next;
    logic       cfg_wait_reg;
    logic       cfg_write;
    logic       accept;
    logic [SPAN_BITS-1:0] leg_span, body_span;

    plan_t      front_plan, head_plan;
    logic       plan_write, plan_take;
    fifo_stat_t fifo_stat;

    // register file
    always_comb
    begin
        cfg_write = cfg_valid && cfg_ready;
        cfg_next  = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LEG_LIFT_MS:      cfg_next.leg_lift_ms      = cfg_data;
                REG_LEG_DROP_MS:      cfg_next.leg_drop_ms      = cfg_data;
                REG_BODY_LEAD_IN_MS:  cfg_next.body_lead_in_ms  = cfg_data;
                REG_ACTUATE_MS:       cfg_next.actuate_ms       = cfg_data;
                REG_BODY_SETTLE_MS:   cfg_next.body_settle_ms   = cfg_data;
                REG_LIFT_FRACTION:    cfg_next.lift_fraction    = $signed(cfg_data);
                REG_ACTUATE_FRACTION: cfg_next.actuate_fraction = cfg_data[14:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // half-step spans from the current registers
    always_comb
    begin
        leg_span  = SPAN_BITS'(cfg_reg.leg_lift_ms) + SPAN_BITS'(cfg_reg.leg_drop_ms);
        body_span = SPAN_BITS'(cfg_reg.body_lead_in_ms) + SPAN_BITS'(cfg_reg.actuate_ms)
                    + SPAN_BITS'(cfg_reg.body_settle_ms);
        span_next.total   = (leg_span > body_span) ? leg_span : body_span;
        span_next.to_drop = span_next.total - SPAN_BITS'(cfg_reg.leg_drop_ms);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leg_lift_ms      <= RST_LEG_LIFT_MS;
            cfg_reg.leg_drop_ms      <= RST_LEG_DROP_MS;
            cfg_reg.body_lead_in_ms  <= RST_BODY_LEAD_IN_MS;
            cfg_reg.actuate_ms       <= RST_ACTUATE_MS;
            cfg_reg.body_settle_ms   <= RST_BODY_SETTLE_MS;
            cfg_reg.lift_fraction    <= RST_LIFT_FRACTION;
            cfg_reg.actuate_fraction <= RST_ACTUATE_FRACTION;
            cfg_wait_reg             <= 1'b1;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            cfg_wait_reg <= cfg_write;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
    end

    // input handshake
    assign cfg_ready = 1'b1;
    assign full      = fifo_stat.full || cfg_wait_reg;
    assign accept    = push && !full;

    dhsg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .span       (span_reg),
        .cfg        (cfg_reg),
        .plan       (front_plan),
        .plan_write (plan_write)
    );

    dhsg_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .write (plan_write),
        .wdata (front_plan),
        .read  (plan_take),
        .rdata (head_plan),
        .stat  (fifo_stat)
    );

    dhsg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan       (head_plan),
        .plan_valid (fifo_stat.not_empty),
        .plan_take  (plan_take),
        .cfg        (cfg_reg),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

    // a word without a command always closes its item
    `DHSG_ASSERT_SAME(a_nocmd_last, !empty && !result.cmd_valid, result.last, "empty word not last")
    // spans reload before the next item enters
    `DHSG_ASSERT_NEXT(a_cfg_block, cfg_write, full, "item accepted on stale spans")
    // plan queue stays within its depth
    `DHSG_ASSERT_SAME(a_fifo_depth, 1'b1, fifo_stat.count <= (FIFO_AW+1)'(FIFO_DEPTH), "queue overrun")
    // back end takes only a queued plan
    `DHSG_ASSERT_SAME(a_take_valid, plan_take, fifo_stat.not_empty, "plan taken from empty queue")

endmodule

// ===== rtl/core/dhsg_fifo.sv =====
`timescale 1ns / 1ps

module dhsg_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                write,
    input  dhsg_pkg::plan_t     wdata,
    input  logic                read,
    output dhsg_pkg::plan_t     rdata,
    output dhsg_pkg::fifo_stat_t stat
);
    import dhsg_pkg::*;

    plan_t              entries [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = write ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = read ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({write, read})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (write)
        begin
            entries[wr_ptr_reg] <= wdata;
        end
    end

    // head entry and status
    always_comb
    begin
        rdata          = entries[rd_ptr_reg];
        stat.count     = count_reg;
        stat.full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
        stat.not_empty = (count_reg != '0);
    end

endmodule

// ===== rtl/core/dhsg_front.sv =====
`timescale 1ns / 1ps

module dhsg_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  dhsg_pkg::item_t item,
    input  dhsg_pkg::span_t span,
    input  dhsg_pkg::cfg_t  cfg,
    output dhsg_pkg::plan_t plan,
    output logic            plan_write
);
    import dhsg_pkg::*;

    logic               active_reg, active_next;
    logic               settling_reg, settling_next;
    logic signed [15:0] remaining_reg, remaining_next;
    logic [2:0]         body_id_reg, body_id_next;
    logic               diag_cur_reg, diag_cur_next;
    logic               diag_nxt_reg, diag_nxt_next;
    tstamp_t            act_time_reg, act_time_next;
    tstamp_t            drop_time_reg, drop_time_next;
    tstamp_t            end_time_reg, end_time_next;
    logic               act_done_reg, act_done_next;
    logic               drop_done_reg, drop_done_next;

    tstamp_t            now_t;
    logic               is_tick;
    logic               act_hit, drop_hit, end_hit;
    logic               begin_hs, begin_diag;
    logic signed [15:0] stepped;
    logic signed [15:0] swing;

    // time comparisons and classification
    always_comb
    begin
        now_t    = to_tstamp(item.now_ms);
        is_tick  = (item.cmd == CMD_TICK);
        act_hit  = active_reg && !act_done_reg && reached(now_t, act_time_reg);
        drop_hit = active_reg && !drop_done_reg && reached(now_t, drop_time_reg);
        end_hit  = active_reg && reached(now_t, end_time_reg);
        if (remaining_reg > 16'sd0)
        begin
            stepped = remaining_reg - 16'sd1;
        end
        else if (remaining_reg < 16'sd0)
        begin
            stepped = remaining_reg + 16'sd1;
        end
        else
        begin
            stepped = remaining_reg;
        end
        swing = $signed({1'b0, cfg.actuate_fraction});
    end

    // next state
    always_comb
    begin
        active_next    = active_reg;
        settling_next  = settling_reg;
        remaining_next = remaining_reg;
        body_id_next   = body_id_reg;
        diag_cur_next  = diag_cur_reg;
        diag_nxt_next  = diag_nxt_reg;
        act_time_next  = act_time_reg;
        drop_time_next = drop_time_reg;
        end_time_next  = end_time_reg;
        act_done_next  = act_done_reg;
        drop_done_next = drop_done_reg;
        begin_hs       = 1'b0;
        begin_diag     = diag_nxt_reg;

        if (accept)
        begin
            if (!is_tick)
            begin
                // start: zero count is ignored
                if (item.half_steps != 16'sd0)
                begin
                    body_id_next   = item.body_servo;
                    remaining_next = item.half_steps;
                    settling_next  = 1'b0;
                    active_next    = 1'b1;
                    begin_hs       = 1'b1;
                    begin_diag     = diag_nxt_reg;
                end
            end
            else if (active_reg)
            begin
                act_done_next  = act_done_reg | act_hit;
                drop_done_next = drop_done_reg | drop_hit;
                if (end_hit)
                begin
                    diag_nxt_next = !diag_cur_reg;
                    if (settling_reg)
                    begin
                        settling_next = 1'b0;
                        active_next   = 1'b0;
                    end
                    else
                    begin
                        remaining_next = stepped;
                        if (stepped == 16'sd0)
                        begin
                            settling_next = 1'b1;
                        end
                        begin_hs   = 1'b1;
                        begin_diag = !diag_cur_reg;
                    end
                end
            end
        end

        // new half-step schedule
        if (begin_hs)
        begin
            diag_cur_next  = begin_diag;
            act_time_next  = now_t + TIME_BITS'(cfg.body_lead_in_ms);
            end_time_next  = now_t + TIME_BITS'(span.total);
            drop_time_next = now_t + TIME_BITS'(span.to_drop);
            act_done_next  = 1'b0;
            drop_done_next = 1'b0;
        end
    end

    // plan for the back end
    always_comb
    begin
        plan_write       = accept;
        plan.act         = is_tick && act_hit;
        plan.body_id     = body_id_reg;
        if (settling_reg)
        begin
            plan.act_frac = 16'sd0;
        end
        else if ((remaining_reg > 16'sd0) == diag_cur_reg)
        begin
            plan.act_frac = swing;
        end
        else
        begin
            plan.act_frac = -swing;
        end
        plan.drop        = is_tick && drop_hit;
        plan.drop_diag_a = diag_cur_reg;
        plan.lift        = begin_hs;
        plan.lift_diag_a = begin_diag;
        plan.done        = !active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            settling_reg  <= 1'b0;
            remaining_reg <= '0;
            body_id_reg   <= '0;
            diag_cur_reg  <= 1'b1;
            diag_nxt_reg  <= 1'b1;
            act_time_reg  <= '0;
            drop_time_reg <= '0;
            end_time_reg  <= '0;
            act_done_reg  <= 1'b0;
            drop_done_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            settling_reg  <= settling_next;
            remaining_reg <= remaining_next;
            body_id_reg   <= body_id_next;
            diag_cur_reg  <= diag_cur_next;
            diag_nxt_reg  <= diag_nxt_next;
            act_time_reg  <= act_time_next;
            drop_time_reg <= drop_time_next;
            end_time_reg  <= end_time_next;
            act_done_reg  <= act_done_next;
            drop_done_reg <= drop_done_next;
        end
    end

endmodule

// ===== rtl/core/dhsg_back.sv =====
`timescale 1ns / 1ps

module dhsg_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dhsg_pkg::plan_t   plan,
    input  logic              plan_valid,
    output logic              plan_take,
    input  dhsg_pkg::cfg_t    cfg,
    output dhsg_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);
    import dhsg_pkg::*;

    // one-hot word slots, issued lowest first
    localparam logic [5:0] SEL_ACT   = 6'b000001;
    localparam logic [5:0] SEL_DROP0 = 6'b000010;
    localparam logic [5:0] SEL_DROP1 = 6'b000100;
    localparam logic [5:0] SEL_LIFT0 = 6'b001000;
    localparam logic [5:0] SEL_LIFT1 = 6'b010000;
    localparam logic [5:0] SEL_NONE  = 6'b100000;

    logic       busy_reg, busy_next;
    logic [5:0] mask_reg, mask_next;
    plan_t      rec_reg, rec_next;
    result_t    out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic       advance;
    logic [5:0] sel, rest, load_mask;
    logic       last_word;
    logic [2:0] drop_base, lift_base;
    result_t    word;

    // slot selection
    always_comb
    begin
        advance   = busy_reg && (!out_valid_reg || pop);
        sel       = mask_reg & (~mask_reg + 6'd1);
        rest      = mask_reg & ~sel;
        last_word = (rest == 6'd0);
        plan_take = plan_valid && (!busy_reg || (advance && last_word));
        load_mask = {!(plan.act || plan.drop || plan.lift),
                     plan.lift, plan.lift, plan.drop, plan.drop, plan.act};
        drop_base = leg_first(rec_reg.drop_diag_a);
        lift_base = leg_first(rec_reg.lift_diag_a);
    end

    // word for the selected slot
    always_comb
    begin
        word.cmd_valid       = 1'b1;
        word.done_res        = rec_reg.done;
        word.last            = last_word;
        case (sel)
            SEL_ACT:
            begin
                word.servo_id        = rec_reg.body_id;
                word.target_fraction = rec_reg.act_frac;
                word.move_ms         = cfg.actuate_ms;
            end
            SEL_DROP0:
            begin
                word.servo_id        = drop_base;
                word.target_fraction = 16'sd0;
                word.move_ms         = cfg.leg_drop_ms;
            end
            SEL_DROP1:
            begin
                word.servo_id        = drop_base + 3'd1;
                word.target_fraction = 16'sd0;
                word.move_ms         = cfg.leg_drop_ms;
            end
            SEL_LIFT0:
            begin
                word.servo_id        = lift_base;
                word.target_fraction = cfg.lift_fraction;
                word.move_ms         = cfg.leg_lift_ms;
            end
            SEL_LIFT1:
            begin
                word.servo_id        = lift_base + 3'd1;
                word.target_fraction = cfg.lift_fraction;
                word.move_ms         = cfg.leg_lift_ms;
            end
            default:
            begin
                // no command for this item
                word.cmd_valid       = 1'b0;
                word.servo_id        = '0;
                word.target_fraction = 16'sd0;
                word.move_ms         = '0;
            end
        endcase
    end

    // expansion and output register
    always_comb
    begin
        busy_next      = busy_reg;
        mask_next      = mask_reg;
        rec_next       = rec_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            mask_next      = rest;
            out_next       = word;
            out_valid_next = 1'b1;
            if (last_word)
            begin
                busy_next = 1'b0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (plan_take)
        begin
            busy_next = 1'b1;
            mask_next = load_mask;
            rec_next  = plan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        out_reg <= out_next;
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule

// ===== sim/diagonal_half_step_gait_sequencer_top_test.sv =====
`timescale 1ns / 1ps

module diagonal_half_step_gait_sequencer_top_test;
    import dhsg_pkg::*;

    // predicts the servo words of the gait sequencer and checks them in order
    class gait_servo_scoreboard;
        cfg_t               regs;
        logic               walking;
        logic               settling;
        logic signed [15:0] steps_left;
        logic [2:0]         body_servo_id;
        logic               diag_a_now;
        logic               diag_a_due;
        tstamp_t            actuate_at;
        tstamp_t            drop_at;
        tstamp_t            end_at;
        logic               actuate_sent;
        logic               drop_sent;
        result_t            words_due[$];
        result_t            step_words[$];
        int                 errors;

        function new();
            regs.leg_lift_ms      = RST_LEG_LIFT_MS;
            regs.leg_drop_ms      = RST_LEG_DROP_MS;
            regs.body_lead_in_ms  = RST_BODY_LEAD_IN_MS;
            regs.actuate_ms       = RST_ACTUATE_MS;
            regs.body_settle_ms   = RST_BODY_SETTLE_MS;
            regs.lift_fraction    = RST_LIFT_FRACTION;
            regs.actuate_fraction = RST_ACTUATE_FRACTION;
            walking       = 1'b0;
            settling      = 1'b0;
            steps_left    = '0;
            body_servo_id = '0;
            diag_a_now    = 1'b1;
            diag_a_due    = 1'b1;
            actuate_at    = '0;
            drop_at       = '0;
            end_at        = '0;
            actuate_sent  = 1'b0;
            drop_sent     = 1'b0;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] v);
            case (idx)
                REG_LEG_LIFT_MS:      regs.leg_lift_ms      = v;
                REG_LEG_DROP_MS:      regs.leg_drop_ms      = v;
                REG_BODY_LEAD_IN_MS:  regs.body_lead_in_ms  = v;
                REG_ACTUATE_MS:       regs.actuate_ms       = v;
                REG_BODY_SETTLE_MS:   regs.body_settle_ms   = v;
                REG_LIFT_FRACTION:    regs.lift_fraction    = v;
                REG_ACTUATE_FRACTION: regs.actuate_fraction = v[14:0];
                default: ;
            endcase
        endfunction

        // wrapping signed difference, reached when not negative
        function logic time_reached(tstamp_t now, tstamp_t at);
            tstamp_t d;
            d = now - at;
            return !d[TIME_BITS-1];
        endfunction

        function void push_move(logic [2:0] servo, logic signed [15:0] frac, logic [15:0] ms);
            result_t r;
            r = '0;
            r.cmd_valid       = 1'b1;
            r.servo_id        = servo;
            r.target_fraction = frac;
            r.move_ms         = ms;
            step_words.push_back(r);
        endfunction

        // both legs of the current diagonal
        function void move_leg_pair(logic signed [15:0] frac, logic [15:0] ms);
            logic [2:0] first;
            first = diag_a_now ? LEG_A_FIRST : LEG_B_FIRST;
            push_move(first, frac, ms);
            push_move(first + 3'd1, frac, ms);
        endfunction

        // lift the next diagonal and schedule actuation, drop and end
        function void begin_half_step(tstamp_t now);
            logic [17:0] leg_span;
            logic [17:0] body_span;
            logic [17:0] total;
            diag_a_now = diag_a_due;
            move_leg_pair(regs.lift_fraction, regs.leg_lift_ms);
            leg_span  = 18'(regs.leg_lift_ms) + 18'(regs.leg_drop_ms);
            body_span = 18'(regs.body_lead_in_ms) + 18'(regs.actuate_ms)
                        + 18'(regs.body_settle_ms);
            total = (leg_span > body_span) ? leg_span : body_span;
            actuate_at   = now + 32'(regs.body_lead_in_ms);
            end_at       = now + 32'(total);
            drop_at      = end_at - 32'(regs.leg_drop_ms);
            actuate_sent = 1'b0;
            drop_sent    = 1'b0;
        endfunction

        function void note_item(item_t w);
            tstamp_t            now;
            logic signed [15:0] swing;
            logic signed [15:0] frac;
            result_t            r;
            now = w.now_ms;
            step_words.delete();
            if (w.cmd == CMD_START) begin
                // zero count leaves everything as it was
                if (w.half_steps != 0) begin
                    body_servo_id = w.body_servo;
                    steps_left    = w.half_steps;
                    settling      = 1'b0;
                    walking       = 1'b1;
                    begin_half_step(now);
                end
            end
            else if (walking) begin
                // body actuation first
                if (!actuate_sent && time_reached(now, actuate_at)) begin
                    swing = {1'b0, regs.actuate_fraction};
                    frac  = '0;
                    if (!settling)
                        frac = ((steps_left > 0) == diag_a_now) ? swing : -swing;
                    push_move(body_servo_id, frac, regs.actuate_ms);
                    actuate_sent = 1'b1;
                end
                if (!drop_sent && time_reached(now, drop_at)) begin
                    move_leg_pair(16'sd0, regs.leg_drop_ms);
                    drop_sent = 1'b1;
                end
                // half-step end: settle out or count and lift the other diagonal
                if (time_reached(now, end_at)) begin
                    diag_a_due = !diag_a_now;
                    if (settling) begin
                        settling = 1'b0;
                        walking  = 1'b0;
                    end
                    else begin
                        if (steps_left > 0)
                            steps_left = steps_left - 16'sd1;
                        else if (steps_left < 0)
                            steps_left = steps_left + 16'sd1;
                        if (steps_left == 0)
                            settling = 1'b1;
                        begin_half_step(now);
                    end
                end
            end
            // an item without a move still answers with one word
            if (step_words.size() == 0) begin
                r = '0;
                step_words.push_back(r);
            end
            foreach (step_words[k]) begin
                r          = step_words[k];
                r.done_res = !walking;
                r.last     = (k == step_words.size() - 1);
                words_due.push_back(r);
            end
        endfunction

        task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
            errors++;
            $display("[%0t] mismatch %s: got %h expected %h", $time, what, got_v, want_v);
        endtask

        task check_word(result_t got);
            result_t want;
            if (words_due.size() == 0) begin
                report_mismatch("unexpected word", 32'(got), '0);
                return;
            end
            want = words_due.pop_front();
            if (got.cmd_valid !== want.cmd_valid)
                report_mismatch("cmd_valid", 32'(got.cmd_valid), 32'(want.cmd_valid));
            if (got.servo_id !== want.servo_id)
                report_mismatch("servo_id", 32'(got.servo_id), 32'(want.servo_id));
            if (got.target_fraction !== want.target_fraction)
                report_mismatch("target_fraction", 32'(got.target_fraction),
                                32'(want.target_fraction));
            if (got.move_ms !== want.move_ms)
                report_mismatch("move_ms", 32'(got.move_ms), 32'(want.move_ms));
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 200000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    item_t                   item = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    result_t                 result;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [15:0]             cfg_data = '0;

    gait_servo_scoreboard sb = new();
    cfg_t                 gait_cfg;
    tstamp_t              walk_ms = '0;
    int                   tx_idle_pct = 20;
    int                   rx_idle_pct = 58;
    int                   hold_left = 0;
    int                   cycle_count = 0;

    diagonal_half_step_gait_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // watch all three handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (push && !full)
                sb.note_item(item);
            if (pop && !empty)
                sb.check_word(result);
        end
    end

    // result side: random stalls plus long hold-offs on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic item_t gait_word(logic c, tstamp_t t, logic [2:0] servo,
                                        logic signed [15:0] n);
        item_t w;
        w.cmd        = c;
        w.now_ms     = t;
        w.body_servo = servo;
        w.half_steps = n;
        return w;
    endfunction

    // offer one word, push stays high until the next call decides
    task automatic send_item(input item_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_gait_regs(input cfg_t c);
        gait_cfg = c;
        put_reg(REG_LEG_LIFT_MS, c.leg_lift_ms);
        put_reg(REG_LEG_DROP_MS, c.leg_drop_ms);
        put_reg(REG_BODY_LEAD_IN_MS, c.body_lead_in_ms);
        put_reg(REG_ACTUATE_MS, c.actuate_ms);
        put_reg(REG_BODY_SETTLE_MS, c.body_settle_ms);
        put_reg(REG_LIFT_FRACTION, c.lift_fraction);
        put_reg(REG_ACTUATE_FRACTION, {1'b0, c.actuate_fraction});
        cfg_valid <= 1'b0;
    endtask

    // stop offering and wait for every predicted word
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.words_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // mostly start-then-ticks walks, some noise and abandoned walks
    task automatic run_gait_bursts(input int n_items);
        int    sent;
        int    mag;
        int    leg_span;
        int    body_span;
        int    span;
        item_t w;
        sent      = 0;
        leg_span  = gait_cfg.leg_lift_ms + gait_cfg.leg_drop_ms;
        body_span = gait_cfg.body_lead_in_ms + gait_cfg.actuate_ms + gait_cfg.body_settle_ms;
        span      = (leg_span > body_span) ? leg_span : body_span;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                mag = $urandom_range(1, 3);
                w = gait_word(CMD_START, walk_ms, 3'($urandom_range(7)),
                              $urandom_range(1) ? 16'(mag) : -16'(mag));
                send_item(w);
                sent++;
                for (int k = 0; k < 4 * (mag + 1) + 2 && sent < n_items; k++)
                begin
                    walk_ms = walk_ms + 32'($urandom_range(0, span / 2 + 1));
                    w = gait_word(CMD_TICK, walk_ms, 3'($urandom_range(7)), 16'($urandom()));
                    send_item(w);
                    sent++;
                end
            end
            else
            begin
                w = gait_word(1'($urandom_range(1)), $urandom(), 3'($urandom_range(7)),
                              16'($urandom()));
                if ($urandom_range(1))
                    walk_ms = w.now_ms;
                send_item(w);
                sent++;
            end
        end
    endtask

    initial
    begin
        tstamp_t t0;
        cfg_t    c;
        gait_cfg.leg_lift_ms      = RST_LEG_LIFT_MS;
        gait_cfg.leg_drop_ms      = RST_LEG_DROP_MS;
        gait_cfg.body_lead_in_ms  = RST_BODY_LEAD_IN_MS;
        gait_cfg.actuate_ms       = RST_ACTUATE_MS;
        gait_cfg.body_settle_ms   = RST_BODY_SETTLE_MS;
        gait_cfg.lift_fraction    = RST_LIFT_FRACTION;
        gait_cfg.actuate_fraction = RST_ACTUATE_FRACTION;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk with reset timing: 100 to actuate, 200 to drop, 400 to end
        t0 = 32'hFFFF_FF80;
        send_item(gait_word(CMD_TICK, 32'd0, 3'd0, 16'sd0));         // idle tick
        send_item(gait_word(CMD_START, 32'd5, 3'd1, 16'sd0));        // zero count start
        send_item(gait_word(CMD_START, t0, 3'd7, 16'sd1));
        send_item(gait_word(CMD_TICK, t0 + 32'd50, 3'd0, 16'sd0));   // too early
        send_item(gait_word(CMD_TICK, t0 + 32'd100, 3'd0, 16'sd0));  // actuation
        send_item(gait_word(CMD_TICK, t0 + 32'd200, 3'd0, 16'sd0));  // drop
        send_item(gait_word(CMD_TICK, t0 + 32'd400, 3'd0, 16'sd0));  // end, time wraps
        send_item(gait_word(CMD_TICK, t0 + 32'd1400, 3'd0, 16'sd0)); // settling, idle
        send_item(gait_word(CMD_START, 32'd100, 3'd3, -16'sd32768));
        send_item(gait_word(CMD_TICK, 32'd500, 3'd0, 16'sd0));       // all five words
        send_item(gait_word(CMD_START, 32'd600, 3'd5, 16'sd32767));  // start while walking
        send_item(gait_word(CMD_TICK, 32'd600 + 32'h8000_0000, 3'd0, 16'sd0)); // half range
        send_item(gait_word(CMD_TICK, 32'd600 + 32'h7FFF_FFFF, 3'd0, 16'sd0));
        send_item(gait_word(CMD_START, 32'd700, 3'd6, 16'sd0));      // ignored mid walk
        send_item(gait_word(CMD_START, 32'd1000, 3'd0, -16'sd1));
        send_item(gait_word(CMD_TICK, 32'd1399, 3'd0, 16'sd0));
        send_item(gait_word(CMD_TICK, 32'd1400, 3'd0, 16'sd0));
        send_item(gait_word(CMD_TICK, 32'd2000, 3'd0, 16'sd0));
        send_item(gait_word(CMD_TICK, 32'd2001, 3'd0, 16'sd0));
        drain();

        // result side holds off while the sender keeps offering
        walk_ms     = 32'd5000;
        tx_idle_pct = 0;
        hold_left   = 80;
        run_gait_bursts(14);
        tx_idle_pct = 20;
        drain();

        // longest durations, most negative lift
        c.leg_lift_ms      = 16'hFFFF;
        c.leg_drop_ms      = 16'hFFFF;
        c.body_lead_in_ms  = 16'hFFFF;
        c.actuate_ms       = 16'hFFFF;
        c.body_settle_ms   = 16'hFFFF;
        c.lift_fraction    = 16'sh8000;
        c.actuate_fraction = 15'h7FFF;
        load_gait_regs(c);
        run_gait_bursts(30);
        drain();

        // zero durations, every tick ends a half-step
        tx_idle_pct = 58;
        rx_idle_pct = 20;
        c.leg_lift_ms      = '0;
        c.leg_drop_ms      = '0;
        c.body_lead_in_ms  = '0;
        c.actuate_ms       = '0;
        c.body_settle_ms   = '0;
        c.lift_fraction    = 16'sh7FFF;
        c.actuate_fraction = '0;
        load_gait_regs(c);
        run_gait_bursts(30);
        drain();

        // random short timing, no stalls on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        c.leg_lift_ms      = 16'($urandom_range(0, 300));
        c.leg_drop_ms      = 16'($urandom_range(0, 300));
        c.body_lead_in_ms  = 16'($urandom_range(0, 300));
        c.actuate_ms       = 16'($urandom_range(0, 300));
        c.body_settle_ms   = 16'($urandom_range(0, 300));
        c.lift_fraction    = 16'($urandom());
        c.actuate_fraction = 15'($urandom());
        load_gait_regs(c);
        run_gait_bursts(30);
        drain();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dhsg_pkg.sv
rtl/core/dhsg_fifo.sv
rtl/core/dhsg_front.sv
rtl/core/dhsg_back.sv
rtl/core/diagonal_half_step_gait_sequencer_top.sv
sim/diagonal_half_step_gait_sequencer_top_test.sv
